/* rtl/clbs_pkg.sv */
// ----------------------------------------------------------------------------
// clbs_pkg
// Shared types and constants of the character-LCD bus sequencer.
// ----------------------------------------------------------------------------
package clbs_pkg;

	// Pending bus writes held between a request and its status polls.
	localparam int QUEUE_DEPTH = 4;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Result words held ahead of the result port.
	localparam int OQ_DEPTH = 3;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LINE_LENGTH = 2'd0,
		CFG_LINE2_BASE  = 2'd1,
		CFG_CHAR_HOLD   = 2'd2,
		CFG_SETTLE_WAIT = 2'd3
	} cfg_idx_t;

	localparam logic [5:0] LINE_LENGTH_RST = 6'd28;
	localparam logic [6:0] LINE2_BASE_RST  = 7'd64;
	localparam logic [7:0] CHAR_HOLD_RST   = 8'd43;
	localparam logic [7:0] SETTLE_WAIT_RST = 8'd8;

	// Request kinds.
	typedef enum logic [2:0] {
		KIND_CMD    = 3'd0,
		KIND_CHAR   = 3'd1,
		KIND_MOVE   = 3'd2,
		KIND_STATUS = 3'd3,
		KIND_INIT   = 3'd4
	} kind_t;

	// Bus operations.
	typedef enum logic [1:0] {
		OP_POLL = 2'd0,
		OP_CMD  = 2'd1,
		OP_DATA = 2'd2
	} bus_op_t;

	// Display command bytes and waits.
	localparam logic [7:0]  SET_DDRAM_ADDR = 8'h80;
	localparam int          BUSY_BIT       = 7;
	localparam logic [15:0] MOVE_HOLD      = 16'd39;
	localparam logic [7:0]  INIT_FUNC_SET  = 8'h38;
	localparam logic [7:0]  INIT_DISP_ON   = 8'h0F;
	localparam logic [7:0]  INIT_ENTRY     = 8'h06;
	localparam logic [7:0]  INIT_CLEAR     = 8'h01;
	localparam logic [15:0] CLEAR_HOLD     = 16'd1530;
	localparam logic [7:0]  ROW_SECOND     = 8'd2;

	// One queued bus write.
	typedef struct packed {
		bus_op_t     op;
		logic [7:0]  data_byte;
		logic [15:0] hold;
	} wq_entry_t;

	// One result word.
	typedef struct packed {
		bus_op_t     op;
		logic [7:0]  data_byte;
		logic [7:0]  settle;
		logic [15:0] hold;
		logic        last;
	} res_t;

	localparam res_t POLL_RES = '{op: OP_POLL, data_byte: 8'd0, settle: 8'd0,
		hold: 16'd0, last: 1'b1};

endpackage

/* rtl/clbs_if.sv */
// ----------------------------------------------------------------------------
// clbs_req_if / clbs_res_if
// Valid/ready channels for requests and status bytes, and for bus results.
// ----------------------------------------------------------------------------
interface clbs_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [7:0]  byte_value;
	logic [15:0] wait_ms;
	logic [7:0]  column;
	logic [7:0]  row;
	logic        first_of_string;

	modport source (output valid, kind, byte_value, wait_ms, column, row,
		first_of_string, input ready);
	modport sink (input valid, kind, byte_value, wait_ms, column, row,
		first_of_string, output ready);
endinterface

interface clbs_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  bus_op;
	logic [7:0]  bus_byte;
	logic [7:0]  settle_ms;
	logic [15:0] hold_ms;
	logic        last;

	modport source (output valid, bus_op, bus_byte, settle_ms, hold_ms, last,
		input ready);
	modport sink (input valid, bus_op, bus_byte, settle_ms, hold_ms, last,
		output ready);
endinterface

/* rtl/char_lcd_bus_sequencer.sv */
// ----------------------------------------------------------------------------
// char_lcd_bus_sequencer
// Turns display requests into queued bus writes, each released by a clear
// status read, with status polls issued in between.
// ----------------------------------------------------------------------------
// The results of an accepted item are registered into the result queue.
// Items are taken at one item per cycle while results drain and each gives one
// result; an item that gives two results, a released write and a poll, places both in the result queue.
// The request side is ready whenever at most one result waits in the 3-entry
// result queue, so a new item is taken while an earlier result is still pending.
// Reset clears the queues, the line position and loads the register defaults.
module char_lcd_bus_sequencer (
	input  logic                          clk,
	input  logic                          arst_n,
	clbs_req_if.sink                      req,
	clbs_res_if.source                    res,
	input  logic                          cfg_we,
	input  logic [clbs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [clbs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import clbs_pkg::*;

	// Configuration registers.
	logic [5:0] line_length_q;
	logic [6:0] line2_base_q;
	logic [7:0] char_hold_q;
	logic [7:0] settle_wait_q;

	// Write queue and line position. A poll is outstanding exactly while the
	// write queue holds entries, so no separate flag is kept.
	wq_entry_t               wq_q [QUEUE_DEPTH];
	wq_entry_t               wq_d [QUEUE_DEPTH];
	logic [QCNT_W-1:0]       wq_cnt_q;
	logic [QCNT_W-1:0]       wq_cnt_d;
	logic [6:0]              cpos_q;
	logic [6:0]              cpos_d;

	// Result queue; entry 0 is presented.
	res_t        oq_q [OQ_DEPTH];
	res_t        oq_d [OQ_DEPTH];
	logic [1:0]  oq_cnt_q;
	logic [1:0]  oq_cnt_d;

	logic        acc;
	logic        pop_res;
	logic [1:0]  n_res;
	res_t        res0;
	res_t        res1;
	logic        pop_wq;
	logic [2:0]  push_n;
	wq_entry_t   push_e [4];
	logic [6:0]  pos_base;
	logic [7:0]  col_m1;
	logic [7:0]  move_addr;
	logic [1:0]  oq_base;

	assign acc     = req.valid && req.ready;
	assign pop_res = res.valid && res.ready;

	assign req.ready     = (oq_cnt_q <= 2'd1);
	assign res.valid     = (oq_cnt_q != 2'd0);
	assign res.bus_op    = oq_q[0].op;
	assign res.bus_byte  = oq_q[0].data_byte;
	assign res.settle_ms = oq_q[0].settle;
	assign res.hold_ms   = oq_q[0].hold;
	assign res.last      = oq_q[0].last;

	// Character position after an optional string restart, and cursor address.
	assign pos_base  = req.first_of_string ? 7'd0 : cpos_q;
	assign col_m1    = req.column - 8'd1;
	assign move_addr = (req.row == ROW_SECOND) ? col_m1 + {1'b0, line2_base_q} : col_m1;

	// Decode one item into pushed writes and results.
	always_comb begin
		n_res  = 2'd0;
		res0   = POLL_RES;
		res1   = POLL_RES;
		pop_wq = 1'b0;
		push_n = 3'd0;
		cpos_d = cpos_q;
		for (int i = 0; i < 4; i++) begin
			push_e[i] = '{op: OP_CMD, data_byte: 8'd0, hold: MOVE_HOLD};
		end
		if (acc) begin
			case (kind_t'(req.kind))
				KIND_STATUS: begin
					if (wq_cnt_q != '0) begin
						n_res = 2'd1;
						if (!req.byte_value[BUSY_BIT]) begin
							pop_wq = 1'b1;
							res0 = '{op: wq_q[0].op, data_byte: wq_q[0].data_byte,
								settle: settle_wait_q, hold: wq_q[0].hold,
								last: (wq_cnt_q == QCNT_W'(1))};
							if (wq_cnt_q != QCNT_W'(1)) begin
								n_res = 2'd2;
							end
						end
					end
				end
				KIND_CMD: begin
					if (wq_cnt_q == '0) begin
						push_n = 3'd1;
						push_e[0] = '{op: OP_CMD, data_byte: req.byte_value,
							hold: req.wait_ms};
					end
				end
				KIND_CHAR: begin
					if (wq_cnt_q == '0) begin
						cpos_d = pos_base;
						if (pos_base < {line_length_q, 1'b0}) begin
							cpos_d = pos_base + 7'd1;
							// Wrap to line two before this character.
							if (pos_base == {1'b0, line_length_q}) begin
								push_n = 3'd2;
								push_e[0] = '{op: OP_CMD,
									data_byte: SET_DDRAM_ADDR | {1'b0, line2_base_q},
									hold: MOVE_HOLD};
								push_e[1] = '{op: OP_DATA, data_byte: req.byte_value,
									hold: {8'd0, char_hold_q}};
							end else begin
								push_n = 3'd1;
								push_e[0] = '{op: OP_DATA, data_byte: req.byte_value,
									hold: {8'd0, char_hold_q}};
							end
						end
					end
				end
				KIND_MOVE: begin
					if (wq_cnt_q == '0) begin
						push_n = 3'd1;
						push_e[0] = '{op: OP_CMD, data_byte: SET_DDRAM_ADDR | move_addr,
							hold: MOVE_HOLD};
					end
				end
				KIND_INIT: begin
					if (wq_cnt_q == '0) begin
						push_n = 3'd4;
						push_e[0] = '{op: OP_CMD, data_byte: INIT_FUNC_SET, hold: MOVE_HOLD};
						push_e[1] = '{op: OP_CMD, data_byte: INIT_DISP_ON, hold: MOVE_HOLD};
						push_e[2] = '{op: OP_CMD, data_byte: INIT_ENTRY, hold: MOVE_HOLD};
						push_e[3] = '{op: OP_CMD, data_byte: INIT_CLEAR, hold: CLEAR_HOLD};
					end
				end
				default: begin
				end
			endcase
			// Every accepted request that queued writes starts a poll.
			if (push_n != 3'd0) begin
				n_res = 2'd1;
			end
		end
	end

	// Write queue: shift out the head on release, load new writes when empty.
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			wq_d[i] = wq_q[i];
			if (pop_wq && i < QUEUE_DEPTH - 1) begin
				wq_d[i] = wq_q[i + 1];
			end
		end
		for (int i = 0; i < 4; i++) begin
			if (3'(i) < push_n) begin
				wq_d[i] = push_e[i];
			end
		end
		wq_cnt_d = wq_cnt_q - QCNT_W'(pop_wq) + QCNT_W'(push_n);
	end

	// Result queue: shift on delivery, append this item's results.
	always_comb begin
		oq_base = oq_cnt_q - {1'b0, pop_res};
		for (int i = 0; i < OQ_DEPTH; i++) begin
			oq_d[i] = oq_q[i];
			if (pop_res && i < OQ_DEPTH - 1) begin
				oq_d[i] = oq_q[i + 1];
			end
			if (n_res != 2'd0 && 2'(i) == oq_base) begin
				oq_d[i] = res0;
			end
			if (n_res == 2'd2 && 2'(i) == oq_base + 2'd1) begin
				oq_d[i] = res1;
			end
		end
		oq_cnt_d = oq_base + n_res;
	end

	// Payload storage.
	always_ff @(posedge clk) begin
		wq_q <= wq_d;
		oq_q <= oq_d;
	end

	// Control state and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wq_cnt_q      <= '0;
			oq_cnt_q      <= 2'd0;
			cpos_q        <= 7'd0;
			line_length_q <= LINE_LENGTH_RST;
			line2_base_q  <= LINE2_BASE_RST;
			char_hold_q   <= CHAR_HOLD_RST;
			settle_wait_q <= SETTLE_WAIT_RST;
		end else begin
			wq_cnt_q <= wq_cnt_d;
			oq_cnt_q <= oq_cnt_d;
			cpos_q   <= cpos_d;
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_LINE_LENGTH: line_length_q <= cfg_data[5:0];
					CFG_LINE2_BASE:  line2_base_q  <= cfg_data[6:0];
					CFG_CHAR_HOLD:   char_hold_q   <= cfg_data;
					CFG_SETTLE_WAIT: settle_wait_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	// The write queue never holds more than its depth.
	a_wq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wq_cnt_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("write queue count beyond depth");

	// Results appended to the result queue always fit in its three entries.
	a_oq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		3'(oq_base) + 3'(n_res) <= 3'(OQ_DEPTH))
		else $error("result queue overflow");

	// A released write that is not last is always followed by a queued poll.
	a_poll_follows: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.last |-> oq_cnt_q >= 2'd2 && oq_q[1].op == OP_POLL)
		else $error("non-last result without a following poll");

	// A request that arrives while writes are pending leaves the queue alone.
	a_busy_drop: assert property (@(posedge clk) disable iff (!arst_n)
		acc && req.kind != KIND_STATUS && wq_cnt_q != '0 |=> $stable(wq_cnt_q))
		else $error("request taken while writes pending");

	// Polls carry no byte and no waits.
	a_poll_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.bus_op == OP_POLL |->
		res.bus_byte == 8'd0 && res.settle_ms == 8'd0 && res.hold_ms == 16'd0)
		else $error("poll with nonzero payload");

endmodule

/* verif/char_lcd_bus_sequencer_checker.sv */
// ----------------------------------------------------------------------------
// char_lcd_bus_sequencer_checker
// Watches the request and result channels and the register port of the LCD
// bus sequencer. It keeps its own copy of the write queue, the line position
// and the registers, works out the bus words that every accepted request or
// status word must cause, and compares each result word with the oldest one
// still due.
// ----------------------------------------------------------------------------
module char_lcd_bus_sequencer_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	clbs_req_if                             req,
	clbs_res_if                             res,
	input  logic                            cfg_we,
	input  logic [clbs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [clbs_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              mismatches,
	output int                              words_due
);
	timeunit 1ns;
	timeprecision 1ps;
	import clbs_pkg::*;

	// Registers as the block should hold them.
	logic [5:0] line_len;
	logic [6:0] second_line_base;
	logic [7:0] char_hold;
	logic [7:0] settle_wait;

	// Pending display writes, in release order.
	wq_entry_t   pending_writes [QUEUE_DEPTH];
	int unsigned pending_count;
	logic        polling;
	logic [6:0]  line_pos;

	// Bus words still to come out of the block, oldest first.
	res_t bus_words_due [$];
	int   fail_tally;

	function automatic void clear_display_state();
		line_len         = LINE_LENGTH_RST;
		second_line_base = LINE2_BASE_RST;
		char_hold        = CHAR_HOLD_RST;
		settle_wait      = SETTLE_WAIT_RST;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			pending_writes[i] = '0;
		end
		pending_count = 0;
		polling       = 1'b0;
		line_pos      = '0;
		bus_words_due.delete();
	endfunction

	// A full queue silently refuses further writes.
	function automatic void queue_write(input bus_op_t op, input logic [7:0] value,
			input logic [15:0] hold);
		if (pending_count < QUEUE_DEPTH) begin
			pending_writes[pending_count] = '{op: op, data_byte: value, hold: hold};
			pending_count++;
		end
	endfunction

	// Status word: a busy display repeats the poll, a ready one releases the
	// head write and, if more writes wait, starts the next poll.
	function automatic void take_status(input logic [7:0] status);
		wq_entry_t head;
		res_t      released;
		if (!polling || pending_count == 0) begin
			return;
		end
		if (status[BUSY_BIT]) begin
			bus_words_due.push_back(POLL_RES);
			return;
		end
		head = pending_writes[0];
		for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
			pending_writes[i] = pending_writes[i+1];
		end
		pending_count--;
		released = '{op: head.op, data_byte: head.data_byte, settle: settle_wait,
			hold: head.hold, last: (pending_count == 0)};
		bus_words_due.push_back(released);
		if (pending_count == 0) begin
			polling = 1'b0;
		end else begin
			bus_words_due.push_back(POLL_RES);
		end
	endfunction

	// Request word: queue its writes and start polling. Requests that arrive
	// while writes are still pending, and unused kinds, leave no trace.
	function automatic void take_request(input logic [2:0] kind, input logic [7:0] value,
			input logic [15:0] hold, input logic [7:0] column, input logic [7:0] row,
			input logic first);
		logic [7:0] addr;
		if (kind > KIND_INIT || pending_count != 0) begin
			return;
		end
		case (kind)
			KIND_CMD: begin
				queue_write(OP_CMD, value, hold);
			end
			KIND_CHAR: begin
				if (first) begin
					line_pos = '0;
				end
				// Past the end of line two the character goes nowhere.
				if (int'(line_pos) >= 2 * int'(line_len)) begin
					return;
				end
				// First character of line two moves the cursor there first.
				if (line_pos == {1'b0, line_len}) begin
					queue_write(OP_CMD, SET_DDRAM_ADDR | {1'b0, second_line_base}, MOVE_HOLD);
				end
				queue_write(OP_DATA, value, {8'd0, char_hold});
				line_pos = line_pos + 7'd1;
			end
			KIND_MOVE: begin
				addr = column - 8'd1;
				if (row == ROW_SECOND) begin
					addr = addr + {1'b0, second_line_base};
				end
				queue_write(OP_CMD, SET_DDRAM_ADDR | addr, MOVE_HOLD);
			end
			default: begin
				queue_write(OP_CMD, INIT_FUNC_SET, MOVE_HOLD);
				queue_write(OP_CMD, INIT_DISP_ON, MOVE_HOLD);
				queue_write(OP_CMD, INIT_ENTRY, MOVE_HOLD);
				queue_write(OP_CMD, INIT_CLEAR, CLEAR_HOLD);
			end
		endcase
		polling = 1'b1;
		bus_words_due.push_back(POLL_RES);
	endfunction

	// Result word against the oldest one due.
	function automatic void check_bus_word();
		res_t seen;
		res_t want;
		seen = '{op: bus_op_t'(res.bus_op), data_byte: res.bus_byte, settle: res.settle_ms,
			hold: res.hold_ms, last: res.last};
		if (bus_words_due.size() == 0) begin
			fail_tally++;
			if (fail_tally <= 10) begin
				$display("%t checker: bus word with none due: op %0d byte %h settle %0d hold %0d last %b",
					$realtime, seen.op, seen.data_byte, seen.settle, seen.hold, seen.last);
			end
			return;
		end
		want = bus_words_due.pop_front();
		if (seen !== want) begin
			fail_tally++;
			if (fail_tally <= 10) begin
				$display("%t checker: expected op %0d byte %h settle %0d hold %0d last %b",
					$realtime, want.op, want.data_byte, want.settle, want.hold, want.last);
				$display("%t checker: actual   op %0d byte %h settle %0d hold %0d last %b",
					$realtime, seen.op, seen.data_byte, seen.settle, seen.hold, seen.last);
			end
		end
	endfunction

	initial begin
		fail_tally = 0;
	end

	// Everything is sampled at the rising edge, before the block's outputs move.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_display_state();
			words_due <= 0;
		end else begin
			if (res.valid && res.ready) begin
				check_bus_word();
			end
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_LINE_LENGTH: line_len         = cfg_data[5:0];
					CFG_LINE2_BASE:  second_line_base = cfg_data[6:0];
					CFG_CHAR_HOLD:   char_hold        = cfg_data;
					default:         settle_wait      = cfg_data;
				endcase
			end
			if (req.valid && req.ready) begin
				if (req.kind == KIND_STATUS) begin
					take_status(req.byte_value);
				end else begin
					take_request(req.kind, req.byte_value, req.wait_ms, req.column, req.row,
						req.first_of_string);
				end
			end
			words_due <= bus_words_due.size();
		end
		mismatches <= fail_tally;
	end

endmodule

/* verif/char_lcd_bus_sequencer_tb.sv */
// ----------------------------------------------------------------------------
// char_lcd_bus_sequencer_tb
// Drives display requests and status words into the LCD bus sequencer under
// several register settings and idle patterns; the checker beside the block
// predicts and compares every bus word, and this module gives the verdict.
// ----------------------------------------------------------------------------
module char_lcd_bus_sequencer_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import clbs_pkg::*;

	localparam int PHASE_ITEMS = 640;
	localparam int LONG_HOLD   = 400;
	localparam int QUIET_TAIL  = 4;

	logic                  clk    = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    words_due;

	int send_idle_pct;
	int recv_idle_pct;
	int holds_asked;
	int holds_done;
	int items_sent;
	int cur_line_len;

	clbs_req_if req ();
	clbs_res_if res ();

	char_lcd_bus_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	char_lcd_bus_sequencer_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.res        (res),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.words_due  (words_due)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Overall time limit.
	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	// Result side: random stalls, plus one long hold-off when asked for.
	initial begin
		res.ready  = 1'b0;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (holds_done != holds_asked) begin
				holds_done++;
				res.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			res.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// One word on the request channel; valid stays up until the next gap.
	task automatic offer(input logic [2:0] kind, input logic [7:0] value,
			input logic [15:0] hold, input logic [7:0] column, input logic [7:0] row,
			input logic first);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid           <= 1'b1;
		req.kind            <= kind;
		req.byte_value      <= value;
		req.wait_ms         <= hold;
		req.column          <= column;
		req.row             <= row;
		req.first_of_string <= first;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic offer_status(input logic busy);
		offer(KIND_STATUS, {busy, 7'($urandom)}, 16'($urandom), 8'($urandom), 8'($urandom),
			1'($urandom));
	endtask

	// Status words that let n writes out, with busy reads mixed in. Now and
	// then one too few or one too many.
	task automatic release_writes(input int n);
		int count;
		count = n;
		if ($urandom_range(99) < 6) begin
			count = n - 1;
		end else if ($urandom_range(99) < 6) begin
			count = n + 1;
		end
		for (int i = 0; i < count; i++) begin
			while ($urandom_range(99) < 25) offer_status(1'b1);
			offer_status(1'b0);
		end
	endtask

	// A string of characters, long enough at times to wrap and overflow.
	task automatic type_string();
		int   len;
		int   pos;
		logic start;
		len = $urandom_range(2 * cur_line_len + 2, 1);
		pos = 0;
		for (int i = 0; i < len; i++) begin
			start = (i == 0) || ($urandom_range(99) < 3);
			if (start) begin
				pos = 0;
			end
			offer(KIND_CHAR, 8'($urandom), 16'($urandom), 8'($urandom), 8'($urandom), start);
			if (pos < 2 * cur_line_len) begin
				release_writes((pos == cur_line_len) ? 2 : 1);
				pos++;
			end
		end
	endtask

	task automatic random_transaction();
		int         pick;
		logic [7:0] column;
		logic [7:0] row;
		pick   = $urandom_range(99);
		column = ($urandom_range(3) == 0) ? 8'($urandom_range(1)) : 8'($urandom);
		row    = ($urandom_range(1) == 0) ? ROW_SECOND : 8'($urandom);
		if (pick < 4) begin
			offer(3'($urandom_range(7, 5)), 8'($urandom), 16'($urandom), column, row,
				1'($urandom));
		end else if (pick < 7) begin
			offer_status(1'($urandom));
		end else if (pick < 22) begin
			offer(KIND_CMD, 8'($urandom), 16'($urandom), column, row, 1'($urandom));
			release_writes(1);
		end else if (pick < 34) begin
			offer(KIND_MOVE, 8'($urandom), 16'($urandom), column, row, 1'($urandom));
			release_writes(1);
		end else if (pick < 40) begin
			offer(KIND_INIT, 8'($urandom), 16'($urandom), column, row, 1'($urandom));
			release_writes(4);
		end else begin
			type_string();
		end
	endtask

	// Stop offering and wait until every bus word due has come out.
	task automatic settle_down();
		req.valid <= 1'b0;
		@(posedge clk);
		while (words_due != 0) @(posedge clk);
		repeat (QUIET_TAIL) @(posedge clk);
	endtask

	task automatic write_regs(input logic [7:0] line_length, input logic [7:0] line2_base,
			input logic [7:0] hold, input logic [7:0] settle);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_LINE_LENGTH;
		cfg_data  <= line_length;
		@(posedge clk);
		cfg_index <= CFG_LINE2_BASE;
		cfg_data  <= line2_base;
		@(posedge clk);
		cfg_index <= CFG_CHAR_HOLD;
		cfg_data  <= hold;
		@(posedge clk);
		cfg_index <= CFG_SETTLE_WAIT;
		cfg_data  <= settle;
		@(posedge clk);
		cfg_we       <= 1'b0;
		cur_line_len = int'(line_length[5:0]);
	endtask

	task automatic random_phase(input int pct_send, input int pct_recv, input logic long_hold);
		int goal;
		send_idle_pct = pct_send;
		recv_idle_pct = pct_recv;
		goal          = items_sent + PHASE_ITEMS;
		while (items_sent < goal) begin
			if (long_hold && holds_asked == 0 && items_sent >= goal - PHASE_ITEMS / 2) begin
				holds_asked++;
			end
			random_transaction();
		end
		// Flush whatever writes a short status run left behind.
		for (int i = 0; i <= QUEUE_DEPTH; i++) begin
			offer_status(1'b0);
		end
		settle_down();
	endtask

	initial begin
		req.valid           = 1'b0;
		req.kind            = '0;
		req.byte_value      = '0;
		req.wait_ms         = '0;
		req.column          = '0;
		req.row             = '0;
		req.first_of_string = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = '0;
		cfg_data            = '0;
		holds_asked         = 0;
		items_sent          = 0;
		send_idle_pct       = 20;
		recv_idle_pct       = 20;
		cur_line_len        = int'(LINE_LENGTH_RST);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: stray status, unused kinds, widest command with a busy
		// read, init, cursor moves with column wrap, a request while busy.
		offer_status(1'b0);
		offer(3'd5, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 1'b1);
		offer(3'd6, 8'h00, 16'h0000, 8'h00, 8'h00, 1'b0);
		offer(3'd7, 8'hA5, 16'h5A5A, 8'h5A, 8'hA5, 1'b1);
		offer(KIND_CMD, 8'hFF, 16'hFFFF, 8'h00, 8'h00, 1'b0);
		offer(KIND_STATUS, 8'h80, 16'h0000, 8'h00, 8'h00, 1'b0);
		offer(KIND_STATUS, 8'h7F, 16'h0000, 8'h00, 8'h00, 1'b0);
		offer(KIND_INIT, 8'h00, 16'h0000, 8'h00, 8'h00, 1'b0);
		repeat (4) offer(KIND_STATUS, 8'h00, 16'h0000, 8'h00, 8'h00, 1'b0);
		offer(KIND_MOVE, 8'h00, 16'h0000, 8'h00, ROW_SECOND, 1'b0);
		offer(KIND_STATUS, 8'h00, 16'h0000, 8'h00, 8'h00, 1'b0);
		offer(KIND_MOVE, 8'h00, 16'h0000, 8'hFF, 8'hFF, 1'b0);
		offer(KIND_CMD, 8'h33, 16'h1234, 8'h00, 8'h00, 1'b0);
		offer(KIND_STATUS, 8'h00, 16'h0000, 8'h00, 8'h00, 1'b0);
		settle_down();

		// Directed: one character per line, so the second wraps and the third
		// falls off the display; then a zero line length drops everything.
		write_regs(8'd1, 8'd127, CHAR_HOLD_RST, SETTLE_WAIT_RST);
		offer(KIND_CHAR, 8'h41, 16'h0000, 8'h00, 8'h00, 1'b1);
		offer(KIND_STATUS, 8'h00, 16'h0000, 8'h00, 8'h00, 1'b0);
		offer(KIND_CHAR, 8'h42, 16'h0000, 8'h00, 8'h00, 1'b0);
		offer(KIND_STATUS, 8'h00, 16'h0000, 8'h00, 8'h00, 1'b0);
		offer(KIND_STATUS, 8'h00, 16'h0000, 8'h00, 8'h00, 1'b0);
		offer(KIND_CHAR, 8'h43, 16'h0000, 8'h00, 8'h00, 1'b0);
		settle_down();
		write_regs(8'd0, 8'd0, 8'd0, 8'd0);
		offer(KIND_CHAR, 8'h44, 16'h0000, 8'h00, 8'h00, 1'b1);
		settle_down();

		// Random phases; upper register bits beyond the field width are set
		// in the first one and must be ignored.
		write_regs(8'hE8, 8'hFF, 8'hFF, 8'h00);
		random_phase(35, 72, 1'b0);
		write_regs(8'd3, 8'd0, 8'd0, 8'hFF);
		random_phase(72, 35, 1'b0);
		write_regs(8'($urandom_range(6, 1)), 8'($urandom), 8'($urandom), 8'($urandom));
		random_phase(0, 0, 1'b1);

		req.valid <= 1'b0;
		for (int n = 0; n < 20000 && words_due != 0; n++) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		if (words_due != 0) begin
			$display("%0d bus words never came out", words_due);
		end
		if (mismatches == 0 && words_due == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
